// ===== rtl/jpeg_block_run_length_coder_assert.svh =====
// assertion macros for the run-length coder control module
// expects signals named clk and rst in the scope of each use
`ifndef JPEG_BLOCK_RUN_LENGTH_CODER_ASSERT_SVH
`define JPEG_BLOCK_RUN_LENGTH_CODER_ASSERT_SVH

`ifndef ASSERT_OFF

// checked only outside reset
`define JBRLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define JBRLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define JBRLC_ASSERT(lbl, prop, msg)
`define JBRLC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/jbrlc_pkg.sv =====
// shared types, codes and helpers for the block run-length coder
// no dependencies
package jbrlc_pkg;

  localparam int REQ_W        = 2;
  localparam int VAL_W        = 4;
  localparam int IDX_W        = 8;
  localparam int TABLE_WORD_W = 32;
  localparam int DC_IDX_W     = 4;
  localparam int AC_DEPTH     = 256;
  localparam int POS_W        = 6;
  localparam int RUN_W        = 6;
  localparam int PHASE_W      = 2;

  localparam logic [REQ_W-1:0] REQ_COEF     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_DC = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE_AC = 2'd2;

  localparam logic [IDX_W-1:0] ZRL_ENTRY      = 8'h0f;
  localparam logic [IDX_W-1:0] EOB_ENTRY      = 8'h00;
  localparam logic [POS_W-1:0] LAST_POS       = 6'd63;
  localparam int               CHROMA_LITERAL = 8;

  // where the word in the output register comes from
  typedef enum logic [1:0] {
    SRC_AC,
    SRC_DC,
    SRC_ZERO,
    SRC_MARK
  } src_t;

  // results still owed for the current item, in emit order
  typedef struct packed {
    logic [1:0]       zrl;
    logic             main;
    src_t             main_src;
    logic [IDX_W-1:0] main_addr;
    logic             eob;
    logic             mark;
  } plan_t;

  typedef struct packed {
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
  } ac_port_t;

  typedef struct packed {
    logic                wr_en;
    logic [DC_IDX_W-1:0] wr_addr;
    logic                rd_en;
    logic [DC_IDX_W-1:0] rd_addr;
  } dc_port_t;

  function automatic logic plan_empty(plan_t p);
    return (p.zrl == 2'd0) && !p.main && !p.eob && !p.mark;
  endfunction

endpackage

// ===== rtl/jbrlc_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module jbrlc_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/jbrlc_ctrl.sv =====
// item sequencer: block position, zero run, table reads and output register
// depends on jbrlc_pkg and jpeg_block_run_length_coder_assert.svh
`include "jpeg_block_run_length_coder_assert.svh"

module jbrlc_ctrl #(
  parameter int CODE_WIDTH     = 32,
  parameter int DC_TABLE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [jbrlc_pkg::REQ_W-1:0]        req_type,
  input  logic [jbrlc_pkg::VAL_W-1:0]        coef_value,
  input  logic                               new_image,
  input  logic [jbrlc_pkg::IDX_W-1:0]        table_index,
  input  logic [jbrlc_pkg::TABLE_WORD_W-1:0] table_word,
  output jbrlc_pkg::ac_port_t                ac_port,
  output jbrlc_pkg::dc_port_t                dc_port,
  output logic [CODE_WIDTH-1:0]              wr_data,
  input  logic [CODE_WIDTH-1:0]              ac_rd_data,
  input  logic [CODE_WIDTH-1:0]              dc_rd_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [CODE_WIDTH-1:0]              code_word,
  output logic                               last
);

  localparam logic [jbrlc_pkg::DC_IDX_W:0] DC_LIMIT = (jbrlc_pkg::DC_IDX_W + 1)'(DC_TABLE_DEPTH);

  logic [jbrlc_pkg::POS_W-1:0]   pos, pos_next;
  logic [jbrlc_pkg::RUN_W-1:0]   run, run_next;
  logic [jbrlc_pkg::PHASE_W-1:0] phase, phase_next;
  jbrlc_pkg::plan_t              pend, pend_next;
  jbrlc_pkg::src_t               out_src;

  logic                          in_accept;
  logic                          coef_accept;
  logic                          slot_free;
  logic                          issue;
  logic                          issue_last;
  jbrlc_pkg::src_t               issue_src;
  logic [jbrlc_pkg::IDX_W-1:0]   issue_addr;
  jbrlc_pkg::plan_t              new_plan, plan_cur, plan_left;

  logic [jbrlc_pkg::POS_W-1:0]   pos_e;
  logic [jbrlc_pkg::RUN_W-1:0]   run_e, run_n;
  logic [jbrlc_pkg::PHASE_W-1:0] phase_e, phase_n;

  assign in_stall    = !jbrlc_pkg::plan_empty(pend);
  assign in_accept   = in_valid && !in_stall;
  assign coef_accept = in_accept && (req_type == jbrlc_pkg::REQ_COEF);
  assign slot_free   = !out_valid || !out_stall;
  assign wr_data     = table_word[CODE_WIDTH-1:0];

  // plan the results of a coefficient item and the state it leaves
  always_comb begin
    pos_e   = new_image ? '0 : pos;
    run_e   = new_image ? '0 : run;
    phase_e = new_image ? '0 : phase;

    new_plan  = '0;
    run_n     = run_e;
    phase_n   = phase_e;

    if (pos_e == '0) begin
      new_plan.main      = 1'b1;
      new_plan.main_src  = ({1'b0, coef_value} < DC_LIMIT) ? jbrlc_pkg::SRC_DC
                                                            : jbrlc_pkg::SRC_ZERO;
      new_plan.main_addr = jbrlc_pkg::IDX_W'(coef_value);
      run_n              = '0;
    end else if (coef_value != '0) begin
      // one zero-run word per full sixteen zeros
      new_plan.zrl       = run_e[5:4];
      new_plan.main      = 1'b1;
      new_plan.main_src  = jbrlc_pkg::SRC_AC;
      new_plan.main_addr = {coef_value, run_e[3:0]};
      run_n              = '0;
    end else begin
      run_n = jbrlc_pkg::RUN_W'(run_e + 1'b1);
    end

    if (pos_e == jbrlc_pkg::LAST_POS) begin
      new_plan.eob = (run_n != '0);
      run_n        = '0;
      phase_n      = jbrlc_pkg::PHASE_W'(phase_e + 1'b1);
      new_plan.mark = (phase_n == '0);
      pos_next     = '0;
    end else begin
      pos_next = jbrlc_pkg::POS_W'(pos_e + 1'b1);
    end

    run_next   = coef_accept ? run_n : run;
    phase_next = coef_accept ? phase_n : phase;
    if (!coef_accept) begin
      pos_next = pos;
    end
  end

  // pick the next result, first one can leave in the cycle of acceptance
  always_comb begin
    plan_cur   = coef_accept ? new_plan : pend;
    plan_left  = plan_cur;
    issue_src  = jbrlc_pkg::SRC_ZERO;
    issue_addr = '0;
    issue      = slot_free && !jbrlc_pkg::plan_empty(plan_cur);

    priority if (plan_cur.zrl != 2'd0) begin
      issue_src     = jbrlc_pkg::SRC_AC;
      issue_addr    = jbrlc_pkg::ZRL_ENTRY;
      plan_left.zrl = plan_cur.zrl - 2'd1;
    end else if (plan_cur.main) begin
      issue_src      = plan_cur.main_src;
      issue_addr     = plan_cur.main_addr;
      plan_left.main = 1'b0;
    end else if (plan_cur.eob) begin
      issue_src     = jbrlc_pkg::SRC_AC;
      issue_addr    = jbrlc_pkg::EOB_ENTRY;
      plan_left.eob = 1'b0;
    end else begin
      issue_src      = jbrlc_pkg::SRC_MARK;
      plan_left.mark = 1'b0;
    end

    issue_last = jbrlc_pkg::plan_empty(plan_left);
    pend_next  = issue ? plan_left : plan_cur;
  end

  always_comb begin
    ac_port.wr_en   = in_accept && (req_type == jbrlc_pkg::REQ_WRITE_AC);
    ac_port.wr_addr = table_index;
    ac_port.rd_en   = issue && (issue_src == jbrlc_pkg::SRC_AC);
    ac_port.rd_addr = issue_addr;

    dc_port.wr_en   = in_accept && (req_type == jbrlc_pkg::REQ_WRITE_DC) &&
                      ({1'b0, table_index[jbrlc_pkg::DC_IDX_W-1:0]} < DC_LIMIT);
    dc_port.wr_addr = table_index[jbrlc_pkg::DC_IDX_W-1:0];
    dc_port.rd_en   = issue && (issue_src == jbrlc_pkg::SRC_DC);
    dc_port.rd_addr = issue_addr[jbrlc_pkg::DC_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      run       <= '0;
      phase     <= '0;
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      pos   <= pos_next;
      run   <= run_next;
      phase <= phase_next;
      pend  <= pend_next;
      if (issue) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_src <= issue_src;
      last    <= issue_last;
    end
  end

  always_comb begin
    unique case (out_src)
      jbrlc_pkg::SRC_AC:   code_word = ac_rd_data;
      jbrlc_pkg::SRC_DC:   code_word = dc_rd_data;
      jbrlc_pkg::SRC_ZERO: code_word = '0;
      jbrlc_pkg::SRC_MARK: code_word = CODE_WIDTH'(jbrlc_pkg::CHROMA_LITERAL);
      default:             code_word = '0;
    endcase
  end

  // a zero run never outgrows the position reached in the block
  `JBRLC_ASSERT(run_below_pos, (run == '0) || (run < pos), "zero run exceeds position")
  // a result that is not final always has a successor queued
  `JBRLC_ASSERT(more_after_nonlast, (out_valid && !last) |-> !jbrlc_pkg::plan_empty(pend),
                "non-final result without pending work")
  // zero-run words are always followed by the coefficient word
  `JBRLC_ASSERT(zrl_before_main, (pend.zrl != 2'd0) |-> pend.main, "zero-run without main word")
  // the marker closes the item
  `JBRLC_ASSERT(mark_is_last, (out_valid && (out_src == jbrlc_pkg::SRC_MARK)) |-> last,
                "marker not final")

endmodule

// ===== rtl/jpeg_block_run_length_coder.sv =====
// Block run-length coder for 64-coefficient blocks, JPEG style.
// Input channel (in_valid / in_stall): one item per handshake, either a
// coefficient size category or a DC / AC table write; other request
// codes are ignored. Output channel (out_valid / out_stall): one code
// word per handshake, last marks the final word caused by an input item.
// A write item gives no result. A coefficient item gives zero to five
// words; its first word enters the output register as soon as that
// register is free, then one word per cycle while the receiver takes
// them. The single output register sends at most one word per cycle.
// The next item is accepted while the final word still waits in the
// output register. While the receiver stalls, the output word holds; write
// items and interior zero coefficients still enter, and the first further
// item that causes words is taken in and then holds the input stalled.
// Reset clears block position, zero run, block phase and the output
// register at once; the code tables keep no reset value and must be
// loaded before use.
// depends on jbrlc_pkg, jbrlc_ram, jbrlc_ctrl
module jpeg_block_run_length_coder #(
  parameter int CODE_WIDTH     = 32,
  parameter int DC_TABLE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [jbrlc_pkg::REQ_W-1:0]        req_type,
  input  logic [jbrlc_pkg::VAL_W-1:0]        coef_value,
  input  logic                               new_image,
  input  logic [jbrlc_pkg::IDX_W-1:0]        table_index,
  input  logic [jbrlc_pkg::TABLE_WORD_W-1:0] table_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [CODE_WIDTH-1:0]              code_word,
  output logic                               last
);

  localparam int DC_AW = $clog2(DC_TABLE_DEPTH);

  jbrlc_pkg::ac_port_t   ac_port;
  jbrlc_pkg::dc_port_t   dc_port;
  logic [CODE_WIDTH-1:0] wr_data;
  logic [CODE_WIDTH-1:0] ac_rd_data;
  logic [CODE_WIDTH-1:0] dc_rd_data;

  jbrlc_ctrl #(
    .CODE_WIDTH     (CODE_WIDTH),
    .DC_TABLE_DEPTH (DC_TABLE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .coef_value  (coef_value),
    .new_image   (new_image),
    .table_index (table_index),
    .table_word  (table_word),
    .ac_port     (ac_port),
    .dc_port     (dc_port),
    .wr_data     (wr_data),
    .ac_rd_data  (ac_rd_data),
    .dc_rd_data  (dc_rd_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_word   (code_word),
    .last        (last)
  );

  jbrlc_ram #(
    .WIDTH (CODE_WIDTH),
    .DEPTH (jbrlc_pkg::AC_DEPTH)
  ) u_ac_table (
    .clk     (clk),
    .wr_en   (ac_port.wr_en),
    .wr_addr (ac_port.wr_addr),
    .wr_data (wr_data),
    .rd_en   (ac_port.rd_en),
    .rd_addr (ac_port.rd_addr),
    .rd_data (ac_rd_data)
  );

  jbrlc_ram #(
    .WIDTH (CODE_WIDTH),
    .DEPTH (DC_TABLE_DEPTH)
  ) u_dc_table (
    .clk     (clk),
    .wr_en   (dc_port.wr_en),
    .wr_addr (dc_port.wr_addr[DC_AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (dc_port.rd_en),
    .rd_addr (dc_port.rd_addr[DC_AW-1:0]),
    .rd_data (dc_rd_data)
  );

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for jpeg_block_run_length_coder: a queue-fed driver,
// a monitor with a built-in run-length predictor, and phased random idling
// depends on jbrlc_pkg and the block's rtl
module testbench;

  localparam int CW = 32;
  localparam int DC_DEPTH = 16;
  localparam logic [jbrlc_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [jbrlc_pkg::REQ_W-1:0] req;
    logic [jbrlc_pkg::VAL_W-1:0] val;
    logic                        start;
    logic [jbrlc_pkg::IDX_W-1:0] idx;
    logic [31:0]                 word;
  } coder_item_t;

  typedef struct packed {
    logic [CW-1:0] word;
    logic          last;
  } code_out_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               in_valid;
  logic                               in_stall;
  logic [jbrlc_pkg::REQ_W-1:0]        req_type;
  logic [jbrlc_pkg::VAL_W-1:0]        coef_value;
  logic                               new_image;
  logic [jbrlc_pkg::IDX_W-1:0]        table_index;
  logic [jbrlc_pkg::TABLE_WORD_W-1:0] table_word;
  logic                               out_valid;
  logic                               out_stall;
  logic [CW-1:0]                      code_word;
  logic                               last;

  coder_item_t items_to_send[$];
  code_out_t   expected_words[$];

  // predictor state
  logic [jbrlc_pkg::POS_W-1:0]   coef_pos;
  logic [jbrlc_pkg::RUN_W-1:0]   zero_count;
  logic [jbrlc_pkg::PHASE_W-1:0] blocks_done;
  logic [CW-1:0]                 dc_words[DC_DEPTH];
  logic [CW-1:0]                 ac_words[jbrlc_pkg::AC_DEPTH];

  // generator side: table entries are loaded just before their first read
  bit dc_loaded[DC_DEPTH];
  bit ac_loaded[jbrlc_pkg::AC_DEPTH];
  int gen_pos = 0;
  int gen_run = 0;

  bit in_fire = 1'b0;
  bit in_hold;
  bit rx_hold;
  bit hold_go;
  int in_idle_pct;
  int out_idle_pct;
  int n_taken = 0;
  int n_fail = 0;

  jpeg_block_run_length_coder #(
    .CODE_WIDTH    (CW),
    .DC_TABLE_DEPTH(DC_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .coef_value (coef_value),
    .new_image  (new_image),
    .table_index(table_index),
    .table_word (table_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_word  (code_word),
    .last       (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic coder_item_t make_item(logic [jbrlc_pkg::REQ_W-1:0] req,
                                            logic [jbrlc_pkg::VAL_W-1:0] val,
                                            logic start, logic [jbrlc_pkg::IDX_W-1:0] idx,
                                            logic [31:0] word);
    coder_item_t it;
    it.req = req;
    it.val = val;
    it.start = start;
    it.idx = idx;
    it.word = word;
    return it;
  endfunction

  task automatic load_dc(input logic [3:0] entry);
    if (!dc_loaded[entry]) begin
      items_to_send.push_back(make_item(jbrlc_pkg::REQ_WRITE_DC, 4'($urandom), 1'($urandom),
                                        {4'($urandom), entry}, pick_word()));
      dc_loaded[entry] = 1'b1;
    end
  endtask

  task automatic load_ac(input logic [jbrlc_pkg::IDX_W-1:0] entry);
    if (!ac_loaded[entry]) begin
      items_to_send.push_back(make_item(jbrlc_pkg::REQ_WRITE_AC, 4'($urandom), 1'($urandom),
                                        entry, pick_word()));
      ac_loaded[entry] = 1'b1;
    end
  endtask

  // queues a coefficient item after the writes of the entries it reads
  task automatic push_coef(input logic [3:0] val, input bit start);
    if (start) begin
      gen_pos = 0;
      gen_run = 0;
    end
    if (gen_pos == 0) begin
      load_dc(val);
      gen_run = 0;
    end else if (val != 0) begin
      if (gen_run > 15) load_ac(jbrlc_pkg::ZRL_ENTRY);
      load_ac({val, 4'(gen_run)});
      gen_run = 0;
    end else begin
      gen_run++;
    end
    if (gen_pos == 63) begin
      if (gen_run != 0) load_ac(jbrlc_pkg::EOB_ENTRY);
      gen_run = 0;
      gen_pos = 0;
    end else begin
      gen_pos++;
    end
    items_to_send.push_back(make_item(jbrlc_pkg::REQ_COEF, val, start, 8'($urandom),
                                      $urandom));
  endtask

  // ignored requests and table rewrites between coefficients
  task automatic push_noise();
    logic [jbrlc_pkg::IDX_W-1:0] idx;
    idx = 8'($urandom);
    case ($urandom_range(2))
      0: items_to_send.push_back(make_item(REQ_UNUSED, 4'($urandom), 1'($urandom), idx,
                                           $urandom));
      1: begin
        items_to_send.push_back(make_item(jbrlc_pkg::REQ_WRITE_DC, 4'($urandom),
                                          1'($urandom), idx, pick_word()));
        dc_loaded[idx[3:0]] = 1'b1;
      end
      default: begin
        items_to_send.push_back(make_item(jbrlc_pkg::REQ_WRITE_AC, 4'($urandom),
                                          1'($urandom), idx, pick_word()));
        ac_loaded[idx] = 1'b1;
      end
    endcase
  endtask

  // works out the code words one accepted item causes
  task automatic run_length_code(input coder_item_t it);
    logic [CW-1:0]               words[$];
    logic [jbrlc_pkg::RUN_W-1:0] run;
    logic [3:0]                  dc_idx;
    case (it.req)
      jbrlc_pkg::REQ_WRITE_DC: begin
        dc_idx = it.idx[3:0];
        if (dc_idx < DC_DEPTH) dc_words[dc_idx] = it.word[CW-1:0];
      end
      jbrlc_pkg::REQ_WRITE_AC: ac_words[it.idx] = it.word[CW-1:0];
      jbrlc_pkg::REQ_COEF: begin
        if (it.start) begin
          coef_pos = '0;
          zero_count = '0;
          blocks_done = '0;
        end
        if (coef_pos == 0) begin
          words.push_back((it.val < DC_DEPTH) ? dc_words[it.val] : '0);
          zero_count = '0;
        end else if (it.val != 0) begin
          run = zero_count;
          // one zero-run word per sixteen pending zeros
          while (run > 15) begin
            words.push_back(ac_words[jbrlc_pkg::ZRL_ENTRY]);
            run = run - 6'd16;
          end
          words.push_back(ac_words[{it.val, run[3:0]}]);
          zero_count = '0;
        end else begin
          zero_count = zero_count + 1'b1;
        end
        if (coef_pos == jbrlc_pkg::LAST_POS) begin
          if (zero_count != 0) words.push_back(ac_words[jbrlc_pkg::EOB_ENTRY]);
          zero_count = '0;
          blocks_done = blocks_done + 1'b1;
          if (blocks_done == 0) words.push_back(CW'(jbrlc_pkg::CHROMA_LITERAL));
          coef_pos = '0;
        end else begin
          coef_pos = coef_pos + 1'b1;
        end
      end
      default: ;
    endcase
    foreach (words[k])
      expected_words.push_back('{word: words[k], last: 1'(k == words.size() - 1)});
  endtask

  // driver: a new item only once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (!in_hold && items_to_send.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_valid <= 1'b1;
        req_type <= items_to_send[0].req;
        coef_value <= items_to_send[0].val;
        new_image <= items_to_send[0].start;
        table_index <= items_to_send[0].idx;
        table_word <= items_to_send[0].word;
        void'(items_to_send.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= rx_hold || ($urandom_range(99) < out_idle_pct);
  end

  // monitor: checks results first, then predicts the item taken at this edge
  always @(posedge clk) begin : monitor
    code_out_t want;
    if (rst) begin
      in_fire = 1'b0;
      coef_pos = '0;
      zero_count = '0;
      blocks_done = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result: code_word %h last %b", code_word, last);
          n_fail++;
        end else begin
          want = expected_words.pop_front();
          if (code_word !== want.word) begin
            $error("code_word: expected %h actual %h", want.word, code_word);
            n_fail++;
          end
          if (last !== want.last) begin
            $error("last: expected %b actual %b", want.last, last);
            n_fail++;
          end
        end
      end
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        n_taken++;
        run_length_code(make_item(req_type, coef_value, new_image, table_index, table_word));
      end
    end
  end

  // long receiver hold while the sender keeps offering
  initial begin : long_hold
    int n;
    wait (hold_go);
    rx_hold = 1'b1;
    for (n = 0; n < 300; n++) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int         n_total;
    int         dens;
    logic [3:0] val;

    rst = 1'b1;
    in_valid = 1'b0;
    req_type = jbrlc_pkg::REQ_COEF;
    coef_value = '0;
    new_image = 1'b0;
    table_index = '0;
    table_word = '0;
    out_stall = 1'b0;
    in_hold = 1'b0;
    rx_hold = 1'b0;
    hold_go = 1'b0;
    in_idle_pct = 26;
    out_idle_pct = 74;

    // directed: field extremes, restart inside a block, ignored items
    push_coef(4'd0, 1'b1);
    push_coef(4'd15, 1'b0);
    push_coef(4'd15, 1'b1);
    items_to_send.push_back(make_item(REQ_UNUSED, 4'd15, 1'b1, 8'hff, 32'hffff_ffff));
    items_to_send.push_back(make_item(jbrlc_pkg::REQ_WRITE_DC, 4'd0, 1'b1, 8'hf3,
                                      32'hffff_ffff));
    dc_loaded[3] = 1'b1;
    items_to_send.push_back(make_item(jbrlc_pkg::REQ_WRITE_AC, 4'd0, 1'b0, 8'hff, 32'h0));
    ac_loaded[255] = 1'b1;
    push_coef(4'd3, 1'b1);
    repeat (15) push_coef(4'd0, 1'b0);
    push_coef(4'd15, 1'b0);

    // four whole blocks after a restart, the last one ends in a marker
    for (int b = 0; b < 4; b++) begin
      case (b)
        0: dens = 12;
        1: dens = 3;
        2: dens = 20;
        default: dens = 0;
      endcase
      for (int p = 0; p < 64; p++) begin
        if ($urandom_range(39) == 0) push_noise();
        if (p == 0) val = 4'($urandom_range(15));
        // last block: long zero run ending in a nonzero last coefficient
        else if (p == 63) val = (b == 3) ? 4'($urandom_range(15, 1)) : 4'd0;
        else if ($urandom_range(99) < dens) val = 4'($urandom_range(15, 1));
        else val = 4'd0;
        push_coef(val, (b == 0) && (p == 0));
      end
    end
    n_total = items_to_send.size();

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // sender pause until the block drains, then swap the idle rates
    do @(negedge clk); while (n_taken < n_total / 3);
    @(posedge clk);
    in_hold = 1'b1;
    do @(negedge clk); while (in_valid || expected_words.size() != 0);
    repeat (8) @(posedge clk);
    in_idle_pct = 74;
    out_idle_pct = 26;
    in_hold = 1'b0;

    do @(negedge clk); while (n_taken < 2 * n_total / 3);
    @(posedge clk);
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_go = 1'b1;

    do @(negedge clk);
    while (items_to_send.size() != 0 || in_valid || expected_words.size() != 0 || rx_hold);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected code words never arrived", expected_words.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
